// ===== hdl/pfc_pkg.sv =====
// shared types, constants and cell arithmetic for the playfair encryptor
`default_nettype none
package pfc_pkg;

    localparam int LetterW = 5;
    localparam int CellW   = 5;
    localparam int Cells   = 25;
    localparam int Letters = 26;

    localparam logic [LetterW-1:0] LETTER_I    = 5'd8;
    localparam logic [LetterW-1:0] LETTER_J    = 5'd9;
    localparam logic [LetterW-1:0] LETTER_X    = 5'd23;
    localparam logic [LetterW-1:0] LETTER_LAST = 5'd25;
    localparam logic [CellW-1:0]   CELL_LAST   = 5'd24;
    localparam logic [2:0]         SIDE_LAST   = 3'd4;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_KEY     = 2'd0;
    localparam cmd_t CMD_KEY_END = 2'd1;
    localparam cmd_t CMD_TEXT    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_PA,
        ST_PB,
        ST_CALC,
        ST_RA,
        ST_WA,
        ST_RB,
        ST_WB
    } state_t;

    typedef struct packed {
        logic               en;
        logic [CellW-1:0]   addr;
        logic [LetterW-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic [CellW-1:0] cell_a;
        logic [CellW-1:0] cell_b;
    } cell_pair_t;

    function automatic logic [2:0] row_of(input logic [CellW-1:0] p);
        logic [2:0] r;
        if (p >= 5'd20)
            r = 3'd4;
        else if (p >= 5'd15)
            r = 3'd3;
        else if (p >= 5'd10)
            r = 3'd2;
        else if (p >= 5'd5)
            r = 3'd1;
        else
            r = 3'd0;
        return r;
    endfunction

    function automatic logic [CellW-1:0] row_base(input logic [2:0] r);
        return {r, 2'b00} + {2'b00, r};
    endfunction

    function automatic logic [2:0] col_of(input logic [CellW-1:0] p);
        logic [CellW-1:0] d;
        d = p - row_base(row_of(p));
        return d[2:0];
    endfunction

    function automatic logic [CellW-1:0] cell_of(input logic [2:0] r, input logic [2:0] c);
        return row_base(r) + {2'b00, c};
    endfunction

    function automatic logic [2:0] wrap_inc(input logic [2:0] v);
        return (v == SIDE_LAST) ? 3'd0 : v + 3'd1;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/playfair_cipher_encrypt_top.sv =====
// top level of the streaming playfair encryptor
//
// input beats on s_axis: tdata[1:0] command (key letter, end of key, plaintext
// letter), tdata[6:2] letter code a=0..z=25, tlast marks the final plaintext
// letter of a message. key letters are placed first-occurrence into the
// square as they are accepted; end of key fills in the rest of the
// alphabet. j is folded into i throughout.
// output beats on m_axis: tdata[4:0] cipher letter, tlast on the last result
// of the input beat that caused it. a plaintext beat gives 0, 2 or 4 results.
// a digraph goes through two position ram reads, one pass through the rule
// unit and two square ram reads, through rams of one read port, one read a cycle.
// a doubled letter at end of message repeats the square reads for the second
// pair. s_axis_tready is high only while the sequencer is idle; a finished
// result waits in the output register and the next input beat is still
// taken. when the receiver stalls, the sequencer holds before loading the
// next result. reset clears the key flags, fill position and pending letter
// but not the square ram; a new key is needed.
`default_nettype none
module playfair_cipher_encrypt_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // cmd[1:0], letter[6:2], zero pad
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic      [7:0] m_axis_tdata,   // cipher_letter[4:0], zero pad
    output logic            m_axis_tlast
);
    import pfc_pkg::*;

    ram_wr_t            sq_wr;
    ram_wr_t            pos_wr;
    logic [CellW-1:0]   sq_raddr;
    logic [LetterW-1:0] sq_rdata;
    logic [LetterW-1:0] pos_raddr;
    logic [CellW-1:0]   pos_rdata;
    logic [LetterW-1:0] out_letter;

    pfc_ram #(
        .Width (LetterW),
        .Depth (Cells)
    ) u_square (
        .clk     (clk),
        .wr_en   (sq_wr.en),
        .wr_addr (sq_wr.addr),
        .wr_data (sq_wr.data),
        .rd_addr (sq_raddr),
        .rd_data (sq_rdata)
    );

    pfc_ram #(
        .Width (CellW),
        .Depth (Letters)
    ) u_position (
        .clk     (clk),
        .wr_en   (pos_wr.en),
        .wr_addr (pos_wr.addr),
        .wr_data (pos_wr.data),
        .rd_addr (pos_raddr),
        .rd_data (pos_rdata)
    );

    pfc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (s_axis_tdata[1:0]),
        .in_letter  (s_axis_tdata[6:2]),
        .in_last    (s_axis_tlast),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_letter (out_letter),
        .out_last   (m_axis_tlast),
        .sq_wr      (sq_wr),
        .sq_raddr   (sq_raddr),
        .sq_rdata   (sq_rdata),
        .pos_wr     (pos_wr),
        .pos_raddr  (pos_raddr),
        .pos_rdata  (pos_rdata)
    );

    assign m_axis_tdata = {3'b000, out_letter};

endmodule
`default_nettype wire

// ===== hdl/pfc_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module pfc_ram #(
    parameter int Width = 5,
    parameter int Depth = 25
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(Depth)-1:0] wr_addr,
    input  wire logic [Width-1:0]         wr_data,
    input  wire logic [$clog2(Depth)-1:0] rd_addr,
    output logic      [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== hdl/pfc_pair_unit.sv =====
// playfair rule unit: two square positions in, two cipher cells out
`default_nettype none
module pfc_pair_unit (
    input  wire logic [pfc_pkg::CellW-1:0] pos_a,
    input  wire logic [pfc_pkg::CellW-1:0] pos_b,
    output pfc_pkg::cell_pair_t            cells
);
    import pfc_pkg::*;

    logic [2:0] ra;
    logic [2:0] ca;
    logic [2:0] rb;
    logic [2:0] cb;

    always_comb
    begin
        ra = row_of(pos_a);
        ca = col_of(pos_a);
        rb = row_of(pos_b);
        cb = col_of(pos_b);
        if (ra == rb)
        begin
            cells.cell_a = cell_of(ra, wrap_inc(ca));
            cells.cell_b = cell_of(rb, wrap_inc(cb));
        end
        else if (ca == cb)
        begin
            cells.cell_a = cell_of(wrap_inc(ra), ca);
            cells.cell_b = cell_of(wrap_inc(rb), cb);
        end
        else
        begin
            cells.cell_a = cell_of(ra, cb);
            cells.cell_b = cell_of(rb, ca);
        end
    end

endmodule
`default_nettype wire

// ===== hdl/pfc_ctrl.sv =====
// sequencer: key load, square fill, digraph pairing and result register
`default_nettype none
module pfc_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire pfc_pkg::cmd_t               in_cmd,
    input  wire logic [pfc_pkg::LetterW-1:0] in_letter,
    input  wire logic                        in_last,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [pfc_pkg::LetterW-1:0] out_letter,
    output logic                             out_last,
    output pfc_pkg::ram_wr_t                 sq_wr,
    output logic      [pfc_pkg::CellW-1:0]   sq_raddr,
    input  wire logic [pfc_pkg::LetterW-1:0] sq_rdata,
    output pfc_pkg::ram_wr_t                 pos_wr,
    output logic      [pfc_pkg::LetterW-1:0] pos_raddr,
    input  wire logic [pfc_pkg::CellW-1:0]   pos_rdata
);
    import pfc_pkg::*;

    state_t               state_reg, state_next;
    logic [Letters-1:0]   used_reg, used_next;
    logic [CellW-1:0]     fill_reg, fill_next;
    logic                 key_ready_reg, key_ready_next;
    logic                 pend_v_reg, pend_v_next;
    logic [LetterW-1:0]   pend_reg, pend_next;
    logic [LetterW-1:0]   m_reg, m_next;
    logic                 rep_reg, rep_next;
    logic                 out_valid_reg, out_valid_next;
    logic [LetterW-1:0]   a_reg, a_next;
    logic [LetterW-1:0]   b_reg, b_next;
    logic [CellW-1:0]     pa_reg, pa_next;
    logic [CellW-1:0]     ea_reg, ea_next;
    logic [CellW-1:0]     eb_reg, eb_next;
    logic [LetterW-1:0]   out_letter_reg, out_letter_next;
    logic                 out_last_reg, out_last_next;

    cell_pair_t           cells;
    logic                 letter_ok;
    logic [LetterW-1:0]   c_merged;
    logic                 out_free;
    logic                 place;
    logic [LetterW-1:0]   place_letter;

    pfc_pair_unit u_pair (
        .pos_a (pa_reg),
        .pos_b (pos_rdata),
        .cells (cells)
    );

    assign letter_ok  = (in_letter <= LETTER_LAST);
    assign c_merged   = (in_letter == LETTER_J) ? LETTER_I : in_letter;
    assign out_free   = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_letter = out_letter_reg;
    assign out_last   = out_last_reg;

    assign place_letter = (state_reg == ST_FILL) ? m_reg : c_merged;
    assign sq_wr.en     = place;
    assign sq_wr.addr   = fill_reg;
    assign sq_wr.data   = place_letter;
    assign pos_wr.en    = place;
    assign pos_wr.addr  = place_letter;
    assign pos_wr.data  = fill_reg;
    assign pos_raddr    = (state_reg == ST_PA) ? a_reg : b_reg;
    assign sq_raddr     = (state_reg == ST_RA || state_reg == ST_WA) ? ea_reg : eb_reg;

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        fill_next       = fill_reg;
        key_ready_next  = key_ready_reg;
        pend_v_next     = pend_v_reg;
        pend_next       = pend_reg;
        m_next          = m_reg;
        rep_next        = rep_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        pa_next         = pa_reg;
        ea_next         = ea_reg;
        eb_next         = eb_reg;
        out_letter_next = out_letter_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        place           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_cmd)
                        CMD_KEY:
                        begin
                            if (!key_ready_reg && letter_ok && !used_reg[c_merged]
                                && fill_reg <= CELL_LAST)
                            begin
                                place = 1'b1;
                                used_next[c_merged] = 1'b1;
                                fill_next = fill_reg + 5'd1;
                            end
                        end
                        CMD_KEY_END:
                        begin
                            if (!key_ready_reg)
                            begin
                                m_next     = '0;
                                state_next = ST_FILL;
                            end
                        end
                        CMD_TEXT:
                        begin
                            if (key_ready_reg)
                            begin
                                rep_next = 1'b0;
                                b_next   = LETTER_X;
                                if (letter_ok && pend_v_reg && pend_reg == c_merged)
                                begin
                                    // doubled letter: pair with x, keep it waiting unless it is the last
                                    a_next      = pend_reg;
                                    rep_next    = in_last;
                                    pend_v_next = !in_last;
                                    state_next  = ST_PA;
                                end
                                else if (letter_ok && pend_v_reg)
                                begin
                                    a_next      = pend_reg;
                                    b_next      = c_merged;
                                    pend_v_next = 1'b0;
                                    state_next  = ST_PA;
                                end
                                else if (letter_ok)
                                begin
                                    pend_next = c_merged;
                                    if (in_last)
                                    begin
                                        a_next      = c_merged;
                                        pend_v_next = 1'b0;
                                        state_next  = ST_PA;
                                    end
                                    else
                                    begin
                                        pend_v_next = 1'b1;
                                    end
                                end
                                else if (in_last)
                                begin
                                    pend_v_next = 1'b0;
                                    if (pend_v_reg)
                                    begin
                                        a_next     = pend_reg;
                                        state_next = ST_PA;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                if (m_reg != LETTER_J && !used_reg[m_reg] && fill_reg <= CELL_LAST)
                begin
                    place = 1'b1;
                    used_next[m_reg] = 1'b1;
                    fill_next = fill_reg + 5'd1;
                end
                if (m_reg == LETTER_LAST)
                begin
                    key_ready_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    m_next = m_reg + 5'd1;
                end
            end
            ST_PA:
            begin
                state_next = ST_PB;
            end
            ST_PB:
            begin
                pa_next    = pos_rdata;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                ea_next    = cells.cell_a;
                eb_next    = cells.cell_b;
                state_next = ST_RA;
            end
            ST_RA:
            begin
                state_next = ST_WA;
            end
            ST_WA:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_letter_next = sq_rdata;
                    out_last_next   = 1'b0;
                    state_next      = ST_RB;
                end
            end
            ST_RB:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_letter_next = sq_rdata;
                    out_last_next   = !rep_reg;
                    if (rep_reg)
                    begin
                        rep_next   = 1'b0;
                        state_next = ST_RA;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            fill_reg      <= '0;
            key_ready_reg <= 1'b0;
            pend_v_reg    <= 1'b0;
            pend_reg      <= '0;
            m_reg         <= '0;
            rep_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            fill_reg      <= fill_next;
            key_ready_reg <= key_ready_next;
            pend_v_reg    <= pend_v_next;
            pend_reg      <= pend_next;
            m_reg         <= m_next;
            rep_reg       <= rep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        pa_reg         <= pa_next;
        ea_reg         <= ea_next;
        eb_reg         <= eb_next;
        out_letter_reg <= out_letter_next;
        out_last_reg   <= out_last_next;
    end

endmodule
`default_nettype wire

// ===== hdl/pfc_checker.sv =====
// port-level checks for the playfair encryptor, bound to the top level
`default_nettype none
module pfc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic [7:0] s_axis_tdata,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast
);
    import pfc_pkg::*;

    // key letters and unused codes finish in the accepting cycle
    a_key_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] != CMD_KEY_END
        && s_axis_tdata[1:0] != CMD_TEXT |=> s_axis_tready)
        else $error("input not ready after key letter beat");

    // a non-final result means the digraph is still in progress
    a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready while a run is unfinished");

    // results are letter codes only
    a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[4:0] <= LETTER_LAST && m_axis_tdata[4:0] != LETTER_J
        && m_axis_tdata[7:5] == 3'b000)
        else $error("cipher letter out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

endmodule

bind playfair_cipher_encrypt_top pfc_checker u_pfc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
